// ===== rtl/fcdma_pkg.sv =====
// Shared types, constants and the register map of the four-channel DMA controller.
package fcdma_pkg;

  // Number of channels in the register map.
  localparam int unsigned NumChannels = 4;

  // Field widths of one bus transaction and of its result.
  localparam int unsigned ActionW = 2;
  localparam int unsigned RegAddrW = 5;
  localparam int unsigned DataW = 8;
  localparam int unsigned ChanSelW = 2;
  localparam int unsigned AddrW = 16;
  localparam int unsigned CountW = 16;

  // Kinds of bus transaction.
  typedef enum logic [ActionW-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_XFER  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Register offsets.
  localparam logic [RegAddrW-1:0] RegCtlBase = 5'h10;
  localparam logic [RegAddrW-1:0] RegPrio    = 5'h14;
  localparam logic [RegAddrW-1:0] RegIntr    = 5'h15;
  localparam logic [RegAddrW-1:0] RegChain   = 5'h16;

  // Byte lanes within a channel's address and count block.
  localparam logic [1:0] LaneAddrHi  = 2'd0;
  localparam logic [1:0] LaneAddrLo  = 2'd1;
  localparam logic [1:0] LaneCountHi = 2'd2;
  localparam logic [1:0] LaneCountLo = 2'd3;

  // Bit positions inside the control registers.
  localparam int unsigned CtlToDevBit = 0;
  localparam int unsigned CtlDownBit  = 3;
  localparam int unsigned StBusyBit   = 6;
  localparam int unsigned StDoneBit   = 7;
  localparam int unsigned IrqFlagBit  = 7;
  localparam int unsigned ChainEnBit  = 0;

  // Read value for offsets that map to no register.
  localparam logic [DataW-1:0] UnmappedData = 8'hff;

  // Channel picked for chaining by chain control bits 2:1.
  localparam logic [ChanSelW-1:0] ChainSel [8] = '{
    2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd3
  };

  // One bus transaction.
  typedef struct packed {
    action_e               action;
    logic [RegAddrW-1:0]   reg_addr;
    logic [DataW-1:0]      write_data;
    logic [ChanSelW-1:0]   req_channel;
  } item_t;

  // The result of one bus transaction.
  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             xfer_valid;
    logic [AddrW-1:0] xfer_address;
    logic             xfer_to_device;
    logic             irq_out;
  } result_t;

endpackage

// ===== rtl/fcdma_regfile.sv =====
// Register file of the DMA controller with the next-state logic of one transaction.
module fcdma_regfile #(
  parameter int unsigned NUM_CHANNELS = fcdma_pkg::NumChannels
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               commit_i,
  input  fcdma_pkg::item_t   item_i,
  output fcdma_pkg::result_t result_o
);

  localparam int unsigned ChW = $clog2(NUM_CHANNELS);

  logic [fcdma_pkg::AddrW-1:0]  addr_q  [NUM_CHANNELS];
  logic [fcdma_pkg::AddrW-1:0]  addr_d  [NUM_CHANNELS];
  logic [fcdma_pkg::CountW-1:0] count_q [NUM_CHANNELS];
  logic [fcdma_pkg::CountW-1:0] count_d [NUM_CHANNELS];
  logic [fcdma_pkg::DataW-1:0]  ctl_q   [NUM_CHANNELS];
  logic [fcdma_pkg::DataW-1:0]  ctl_d   [NUM_CHANNELS];
  logic [fcdma_pkg::DataW-1:0]  prio_q, prio_d;
  logic [fcdma_pkg::DataW-1:0]  intr_q, intr_d;
  logic [fcdma_pkg::DataW-1:0]  chain_q, chain_d;

  // Next state and result of the transaction held in the input register.
  always_comb begin
    logic [ChW-1:0]               blk_ch;
    logic [ChW-1:0]               ctl_ch;
    logic [ChW-1:0]               req_ch;
    logic [fcdma_pkg::AddrW-1:0]  step_addr;
    logic [fcdma_pkg::CountW-1:0] step_count;
    logic [fcdma_pkg::AddrW-1:0]  last_addr;
    logic [fcdma_pkg::CountW-1:0] last_count;
    logic                         recompute;
    logic                         any_irq;

    addr_d  = addr_q;
    count_d = count_q;
    ctl_d   = ctl_q;
    prio_d  = prio_q;
    intr_d  = intr_q;
    chain_d = chain_q;
    result_o = '0;
    recompute = 1'b0;
    any_irq = 1'b0;

    blk_ch = item_i.reg_addr[ChW+1:2];
    ctl_ch = item_i.reg_addr[ChW-1:0];
    req_ch = item_i.req_channel[ChW-1:0];
    step_addr = addr_q[req_ch];
    step_count = count_q[req_ch];
    last_addr = addr_q[NUM_CHANNELS-1];
    last_count = count_q[NUM_CHANNELS-1];

    case (item_i.action)
      fcdma_pkg::ACT_WRITE: begin
        if (item_i.reg_addr < fcdma_pkg::RegCtlBase) begin
          case (item_i.reg_addr[1:0])
            fcdma_pkg::LaneAddrHi: addr_d[blk_ch][15:8] = item_i.write_data;
            fcdma_pkg::LaneAddrLo: addr_d[blk_ch][7:0] = item_i.write_data;
            fcdma_pkg::LaneCountHi: count_d[blk_ch][15:8] = item_i.write_data;
            default: count_d[blk_ch][7:0] = item_i.write_data;
          endcase
        end else if (item_i.reg_addr < fcdma_pkg::RegPrio) begin
          // Busy and done belong to the hardware.
          ctl_d[ctl_ch] = {ctl_q[ctl_ch][fcdma_pkg::StDoneBit:fcdma_pkg::StBusyBit],
                           item_i.write_data[fcdma_pkg::StBusyBit-1:0]};
        end else if (item_i.reg_addr == fcdma_pkg::RegPrio) begin
          prio_d = item_i.write_data;
        end else if (item_i.reg_addr == fcdma_pkg::RegIntr) begin
          // The interrupt flag is kept.
          intr_d = {intr_q[fcdma_pkg::IrqFlagBit],
                    item_i.write_data[fcdma_pkg::IrqFlagBit-1:0]};
        end else if (item_i.reg_addr == fcdma_pkg::RegChain) begin
          chain_d = item_i.write_data;
        end
      end
      fcdma_pkg::ACT_READ: begin
        if (item_i.reg_addr < fcdma_pkg::RegCtlBase) begin
          case (item_i.reg_addr[1:0])
            fcdma_pkg::LaneAddrHi: result_o.read_data = addr_q[blk_ch][15:8];
            fcdma_pkg::LaneAddrLo: result_o.read_data = addr_q[blk_ch][7:0];
            fcdma_pkg::LaneCountHi: result_o.read_data = count_q[blk_ch][15:8];
            default: result_o.read_data = count_q[blk_ch][7:0];
          endcase
        end else if (item_i.reg_addr < fcdma_pkg::RegPrio) begin
          // Reading a control register acknowledges its done bit.
          result_o.read_data = ctl_q[ctl_ch];
          if (ctl_q[ctl_ch][fcdma_pkg::StDoneBit]) begin
            ctl_d[ctl_ch][fcdma_pkg::StDoneBit] = 1'b0;
            recompute = 1'b1;
          end
        end else if (item_i.reg_addr == fcdma_pkg::RegPrio) begin
          result_o.read_data = prio_q;
        end else if (item_i.reg_addr == fcdma_pkg::RegIntr) begin
          result_o.read_data = intr_q;
        end else if (item_i.reg_addr == fcdma_pkg::RegChain) begin
          result_o.read_data = chain_q;
        end else begin
          result_o.read_data = fcdma_pkg::UnmappedData;
        end
      end
      fcdma_pkg::ACT_XFER: begin
        if (prio_q[req_ch]) begin
          result_o.xfer_valid = 1'b1;
          result_o.xfer_address = addr_q[req_ch];
          result_o.xfer_to_device = ctl_q[req_ch][fcdma_pkg::CtlToDevBit];
          if (ctl_q[req_ch][fcdma_pkg::CtlDownBit]) begin
            step_addr = addr_q[req_ch] - 16'd1;
          end else begin
            step_addr = addr_q[req_ch] + 16'd1;
          end
          step_count = count_q[req_ch] - 16'd1;
          addr_d[req_ch] = step_addr;
          count_d[req_ch] = step_count;
          if (step_count == '0) begin
            // The last channel reloads from itself after its own step.
            if (req_ch == ChW'(NUM_CHANNELS - 1)) begin
              last_addr = step_addr;
              last_count = step_count;
            end
            if (chain_q[fcdma_pkg::ChainEnBit] &&
                (req_ch == fcdma_pkg::ChainSel[{1'b0, chain_q[2:1]}][ChW-1:0])) begin
              addr_d[req_ch] = last_addr;
              count_d[req_ch] = last_count;
            end
            ctl_d[req_ch][fcdma_pkg::StDoneBit] = 1'b1;
            ctl_d[req_ch][fcdma_pkg::StBusyBit] = 1'b0;
            recompute = 1'b1;
          end else begin
            ctl_d[req_ch][fcdma_pkg::StBusyBit] = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // Interrupt flag, recomputed when a done bit changes: any done channel whose interrupt is enabled.
    for (int unsigned i = 0; i < NUM_CHANNELS; i++) begin
      any_irq = any_irq | (ctl_d[i][fcdma_pkg::StDoneBit] & intr_q[i]);
    end
    if (recompute) begin
      intr_d[fcdma_pkg::IrqFlagBit] = any_irq;
    end
    result_o.irq_out = intr_d[fcdma_pkg::IrqFlagBit];
  end

  // State registers change only when a transaction is committed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NUM_CHANNELS; i++) begin
        addr_q[i]  <= '0;
        count_q[i] <= '0;
        ctl_q[i]   <= '0;
      end
      prio_q  <= '0;
      intr_q  <= '0;
      chain_q <= '0;
    end else if (commit_i) begin
      addr_q  <= addr_d;
      count_q <= count_d;
      ctl_q   <= ctl_d;
      prio_q  <= prio_d;
      intr_q  <= intr_d;
      chain_q <= chain_d;
    end
  end

endmodule

// ===== rtl/four_channel_dma_controller.sv =====
// Top level of the four-channel DMA controller: input register, register file, result register.
//
// The controller takes one bus transaction per clock cycle (register write, register read or
// channel transfer request) and returns one result per transaction: it first waits in the input
// register, then the register file updates and the result register loads at the same edge, so
// the next transaction already sees the new state. Throughput is one transaction per cycle while
// results are taken; a stalled result holds in the result register while one more transaction
// waits in the input register, after which in_ready_o drops. No clearing pass follows reset.
module four_channel_dma_controller #(
  parameter int unsigned NUM_CHANNELS = fcdma_pkg::NumChannels
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [fcdma_pkg::ActionW-1:0]      action_i,
  input  logic [fcdma_pkg::RegAddrW-1:0]     reg_addr_i,
  input  logic [fcdma_pkg::DataW-1:0]        write_data_i,
  input  logic [fcdma_pkg::ChanSelW-1:0]     req_channel_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [fcdma_pkg::DataW-1:0]        read_data_o,
  output logic                               xfer_valid_o,
  output logic [fcdma_pkg::AddrW-1:0]        xfer_address_o,
  output logic                               xfer_to_device_o,
  output logic                               irq_out_o
);

  logic               item_valid_q;
  fcdma_pkg::item_t   item_q;
  logic               out_valid_q;
  fcdma_pkg::result_t result_q;
  fcdma_pkg::result_t result_d;
  logic               advance;
  logic               take_in;

  // A held transaction moves on when the result register is free or being emptied.
  assign advance = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;
  assign take_in = in_valid_i && in_ready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (take_in) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      item_q.action      <= fcdma_pkg::action_e'(action_i);
      item_q.reg_addr    <= reg_addr_i;
      item_q.write_data  <= write_data_i;
      item_q.req_channel <= req_channel_i;
    end
  end

  fcdma_regfile #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .commit_i(advance),
    .item_i  (item_q),
    .result_o(result_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = result_q.read_data;
  assign xfer_valid_o     = result_q.xfer_valid;
  assign xfer_address_o   = result_q.xfer_address;
  assign xfer_to_device_o = result_q.xfer_to_device;
  assign irq_out_o        = result_q.irq_out;

endmodule

// ===== rtl/fcdma_checker.sv =====
// Port-level checks for the DMA controller, bound to the top level.
module fcdma_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [fcdma_pkg::DataW-1:0]    read_data_o,
  input logic                           xfer_valid_o,
  input logic [fcdma_pkg::AddrW-1:0]    xfer_address_o,
  input logic                           xfer_to_device_o,
  input logic                           irq_out_o
);

  // A result that is not taken stays put.
  property p_result_holds;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o) &&
        $stable(xfer_valid_o) && $stable(xfer_address_o) &&
        $stable(xfer_to_device_o) && $stable(irq_out_o);
  endproperty
  a_result_holds: assert property (p_result_holds) else $error("result changed while stalled");

  // The input side only stalls behind a stalled result.
  property p_stall_cause;
    @(posedge clk_i) disable iff (!rst_ni)
      !in_ready_o |-> out_valid_o && !out_ready_i;
  endproperty
  a_stall_cause: assert property (p_stall_cause) else $error("input stalled without cause");

  // A transfer transaction never returns read data.
  property p_xfer_no_data;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && xfer_valid_o |-> read_data_o == '0;
  endproperty
  a_xfer_no_data: assert property (p_xfer_no_data) else $error("transfer with read data");

  // Without a transfer cycle the transfer fields are quiet.
  property p_no_xfer_quiet;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !xfer_valid_o |-> xfer_address_o == '0 && !xfer_to_device_o;
  endproperty
  a_no_xfer_quiet: assert property (p_no_xfer_quiet) else $error("transfer fields without transfer");

  // No result appears unless an earlier transaction was accepted.
  a_no_spurious: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2) ||
        $past(!in_ready_o || out_valid_o, 1)
  ) else $error("result without transaction");

endmodule

bind four_channel_dma_controller fcdma_checker u_fcdma_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .read_data_o     (read_data_o),
  .xfer_valid_o    (xfer_valid_o),
  .xfer_address_o  (xfer_address_o),
  .xfer_to_device_o(xfer_to_device_o),
  .irq_out_o       (irq_out_o)
);
